// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL. Define NO_ASSERTIONS to
// compile them away.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising edge of clk while rst_n is high.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)

`endif

`endif

// ----- src/svmf_pkg.sv -----
// ---------------------------------------------------------------------------
// svmf_pkg
// Sizes, codes and constants of the sample voice mixer with fades.
// ---------------------------------------------------------------------------
package svmf_pkg;

    localparam int NUM_VOICES   = 8;
    // Must be a power of two: addresses wrap by dropping high bits.
    localparam int SAMPLE_DEPTH = 65536;

    localparam int ADDR_W   = $clog2(SAMPLE_DEPTH);
    localparam int VIDX_W   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int POS_W    = 17;
    localparam int FADE_W   = 12;
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 17;
    localparam int QUOT_W   = 16;
    localparam int SUM_W    = SAMPLE_W + VIDX_W + 1;
    localparam int TDATA_W  = 72;
    localparam int TUSER_W  = 2;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);
    localparam logic [FADE_W-1:0] FADE_RESET = FADE_W'(240);

    typedef enum logic [TUSER_W-1:0] {
        MODE_LOAD    = 2'd0,
        MODE_TRIGGER = 2'd1,
        MODE_STOP    = 2'd2,
        MODE_TICK    = 2'd3
    } t_mode;

endpackage

// ----- src/sample_voice_mixer_with_fades_core.sv -----
// ---------------------------------------------------------------------------
// sample_voice_mixer_with_fades_core
// Polyphonic one-shot sample player with linear fades and a mono mix.
// ---------------------------------------------------------------------------
// Usage:
// The slave stream carries commands; tuser is the mode (load, trigger, stop,
// tick). Load writes one sample word into the sample memory, trigger starts
// a voice on a slice, stop silences every voice. None of these gives a beat
// on the master stream. A tick walks the voices one after the other with
// one shared restoring divider and one shared 18x18 multiplier and gives
// one saturated mixed sample on the master stream. An idle or ended voice
// is only checked, marked idle and passed over; a playing voice gets its two
// fade gains, each unity outside the fade region and a quotient of 16 bits
// from the divider inside it, then two multiplies and an accumulation.
// tready is high only while the sequencer is idle. The result sits in an
// output register, so commands are taken while it waits; a following tick
// finishes its walk and then waits until that register is free.
// fade_length is written through i_cfg_we/i_cfg_wdata; the user must do so
// only while idle, as the block itself does not enforce it.
// Reset clears all voices and restores fade_length to 240; the sample memory
// is not cleared and must be loaded before it is played.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sample_voice_mixer_with_fades_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [svmf_pkg::FADE_W-1:0]         i_cfg_wdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // Fields from bit 0 up: load_address[15:0], load_sample[31:16],
    // slice_start[47:32], slice_end[64:48], zero padding[71:65].
    input  logic [svmf_pkg::TDATA_W-1:0]        i_s_axis_tdata,
    // Fields from bit 0 up: mode[1:0].
    input  logic [svmf_pkg::TUSER_W-1:0]        i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // Fields from bit 0 up: mixed_sample[15:0].
    output logic [svmf_pkg::SAMPLE_W-1:0]       o_m_axis_tdata
);
    import svmf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_GAIN,
        S_DIV,
        S_MUL_G,
        S_MUL_S,
        S_ACC,
        S_PUSH
    } t_state;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-32768);

    t_state                   r_state;
    logic [FADE_W-1:0]        r_fade_length;
    logic [NUM_VOICES-1:0]    r_v_active;
    logic [POS_W-1:0]         r_v_start [NUM_VOICES];
    logic [POS_W-1:0]         r_v_end   [NUM_VOICES];
    logic [POS_W-1:0]         r_v_ph    [NUM_VOICES];
    logic [VIDX_W-1:0]        r_vidx;
    logic                     r_phase;
    logic [FADE_W-1:0]        r_rem;
    logic [QUOT_W-1:0]        r_quot;
    logic [3:0]               r_cnt;
    logic [GAIN_W-1:0]        r_gain_in;
    logic [GAIN_W-1:0]        r_gain_out;
    logic signed [35:0]       r_prod;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_m_valid;
    logic [SAMPLE_W-1:0]      r_m_data;
    logic signed [SAMPLE_W-1:0] r_rdata;
    logic signed [SAMPLE_W-1:0] r_mem [SAMPLE_DEPTH];

    logic                     in_accept;
    t_mode                    in_mode;
    logic [15:0]              in_addr;
    logic [SAMPLE_W-1:0]      in_sample;
    logic [POS_W-1:0]         in_start;
    logic [POS_W-1:0]         in_end;
    logic [VIDX_W-1:0]        trig_target;
    logic [16+ADDR_W-1:0]     wr_addr_ext;
    logic [POS_W+ADDR_W-1:0]  rd_addr_ext;
    logic [POS_W-1:0]         c_ph;
    logic [POS_W-1:0]         c_st;
    logic [POS_W-1:0]         c_en;
    logic [POS_W-1:0]         ph_next;
    logic [POS_W-1:0]         fade_dist;
    logic                     dist_lt;
    logic [FADE_W:0]          rem2;
    logic                     rem_ge;
    logic [FADE_W-1:0]        rem_next;
    logic [QUOT_W-1:0]        quot_next;
    logic [GAIN_W-1:0]        gain;
    logic signed [17:0]       mul_a;
    logic signed [17:0]       mul_b;
    logic signed [35:0]       mul_p;
    logic signed [SUM_W-1:0]  contrib;
    logic                     last_voice;
    logic [SAMPLE_W-1:0]      sat_sum;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign in_mode         = t_mode'(i_s_axis_tuser);
    assign in_addr         = i_s_axis_tdata[15:0];
    assign in_sample       = i_s_axis_tdata[31:16];
    assign in_start        = {1'b0, i_s_axis_tdata[47:32]};
    assign in_end          = i_s_axis_tdata[64:48];
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    // A trigger takes the lowest idle voice, or voice 0 when all are busy.
    always_comb begin
        trig_target = '0;
        for (int v = NUM_VOICES - 1; v >= 0; v--) begin
            if (!r_v_active[v]) begin
                trig_target = VIDX_W'(v);
            end
        end
    end

    assign c_ph       = r_v_ph[r_vidx];
    assign c_st       = r_v_start[r_vidx];
    assign c_en       = r_v_end[r_vidx];
    assign ph_next    = c_ph + POS_W'(1);
    assign last_voice = (r_vidx == VIDX_W'(NUM_VOICES - 1));

    assign wr_addr_ext = {{ADDR_W{1'b0}}, in_addr};
    assign rd_addr_ext = {{ADDR_W{1'b0}}, c_ph};

    // Distance into the fade-in on the first pass, to the slice end on the second.
    always_comb begin
        if (r_phase) begin
            fade_dist = c_en - c_ph;
        end else if (c_ph >= c_st) begin
            fade_dist = c_ph - c_st;
        end else begin
            fade_dist = '0;
        end
    end
    assign dist_lt = (fade_dist < {{(POS_W-FADE_W){1'b0}}, r_fade_length});

    // One bit of the restoring division (fade_dist << 16) / fade_length.
    assign rem2      = {r_rem, 1'b0};
    assign rem_ge    = (rem2 >= {1'b0, r_fade_length});
    assign rem_next  = rem_ge ? FADE_W'(rem2 - {1'b0, r_fade_length}) : rem2[FADE_W-1:0];
    assign quot_next = {r_quot[QUOT_W-2:0], rem_ge};

    // Shared multiplier: gain_in * gain_out, then sample * gain.
    assign gain = r_prod[32:16];
    always_comb begin
        if (r_state == S_MUL_G) begin
            mul_a = $signed({1'b0, r_gain_in});
            mul_b = $signed({1'b0, r_gain_out});
        end else begin
            mul_a = {{2{r_rdata[SAMPLE_W-1]}}, r_rdata};
            mul_b = $signed({1'b0, gain});
        end
    end
    assign mul_p = mul_a * mul_b;

    // The arithmetic shift gives the floor, also for negative products.
    assign contrib = SUM_W'($signed(r_prod[35:16]));

    always_comb begin
        if (r_sum > SAT_HI) begin
            sat_sum = 16'h7fff;
        end else if (r_sum < SAT_LO) begin
            sat_sum = 16'h8000;
        end else begin
            sat_sum = r_sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && in_mode == MODE_LOAD) begin
            r_mem[wr_addr_ext[ADDR_W-1:0]] <= in_sample;
        end
        r_rdata <= r_mem[rd_addr_ext[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_fade_length <= FADE_RESET;
            r_v_active    <= '0;
            r_m_valid     <= 1'b0;
            r_vidx        <= '0;
            r_phase       <= 1'b0;
            r_cnt         <= '0;
            for (int v = 0; v < NUM_VOICES; v++) begin
                r_v_start[v] <= '0;
                r_v_end[v]   <= '0;
                r_v_ph[v]    <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_fade_length <= i_cfg_wdata;
            end
            // The push step reloads the output register itself.
            if (r_m_valid && i_m_axis_tready && r_state != S_PUSH) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        unique case (in_mode)
                            MODE_LOAD: begin
                            end
                            MODE_TRIGGER: begin
                                if (in_start < in_end) begin
                                    r_v_start[trig_target]  <= in_start;
                                    r_v_end[trig_target]    <= in_end;
                                    r_v_ph[trig_target]     <= in_start;
                                    r_v_active[trig_target] <= 1'b1;
                                end
                            end
                            MODE_STOP: begin
                                r_v_active <= '0;
                            end
                            MODE_TICK: begin
                                r_vidx  <= '0;
                                r_sum   <= '0;
                                r_state <= S_CHECK;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_CHECK: begin
                    r_phase <= 1'b0;
                    if (r_v_active[r_vidx] && c_ph < c_en) begin
                        r_state <= S_GAIN;
                    end else begin
                        // A voice at or past its end plays nothing and goes idle.
                        r_v_active[r_vidx] <= 1'b0;
                        if (last_voice) begin
                            r_state <= S_PUSH;
                        end else begin
                            r_vidx <= r_vidx + VIDX_W'(1);
                        end
                    end
                end
                S_GAIN: begin
                    if (dist_lt) begin
                        r_rem   <= fade_dist[FADE_W-1:0];
                        r_quot  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else if (!r_phase) begin
                        r_gain_in <= GAIN_ONE;
                        r_phase   <= 1'b1;
                    end else begin
                        r_gain_out <= GAIN_ONE;
                        r_state    <= S_MUL_G;
                    end
                end
                S_DIV: begin
                    r_rem  <= rem_next;
                    r_quot <= quot_next;
                    // The count wraps back to zero after the last bit.
                    r_cnt  <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        if (!r_phase) begin
                            r_gain_in <= {1'b0, quot_next};
                            r_phase   <= 1'b1;
                            r_state   <= S_GAIN;
                        end else begin
                            r_gain_out <= {1'b0, quot_next};
                            r_state    <= S_MUL_G;
                        end
                    end
                end
                S_MUL_G: begin
                    r_prod  <= mul_p;
                    r_state <= S_MUL_S;
                end
                S_MUL_S: begin
                    r_prod  <= mul_p;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sum          <= r_sum + contrib;
                    r_v_ph[r_vidx] <= ph_next;
                    if (ph_next >= c_en) begin
                        r_v_active[r_vidx] <= 1'b0;
                    end
                    if (last_voice) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_vidx  <= r_vidx + VIDX_W'(1);
                        r_state <= S_CHECK;
                    end
                end
                S_PUSH: begin
                    if (!r_m_valid || i_m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= sat_sum;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A new result beat appears only when a tick finishes its voice walk.
    `ASSERT_CLK_RST(a_result_from_push, i_clk, i_rst_n, $rose(r_m_valid) |-> $past(r_state) == S_PUSH, "result beat raised outside the push step")
    // The division remainder always stays below the fade length.
    `ASSERT_CLK_RST(a_rem_below_fade, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_rem < r_fade_length), "division remainder not below fade length")
    // The combined gain never exceeds unity.
    `ASSERT_CLK_RST(a_gain_le_one, i_clk, i_rst_n, (r_state == S_MUL_S) |-> (r_prod <= 36'sh100000000), "combined fade gain above one")
    // A tick starts its walk at voice 0 with an empty sum.
    `ASSERT_CLK_RST(a_tick_starts_clean, i_clk, i_rst_n, (in_accept && in_mode == MODE_TICK) |=> (r_state == S_CHECK && r_vidx == '0 && r_sum == '0), "tick did not start at voice zero")

endmodule
